@@ design/ssscan_pkg.sv @@
`default_nettype none
package ssscan_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_LOAD_COEF    = 2'd0;
  localparam action_t ACT_SAMPLE       = 2'd1;
  localparam action_t ACT_WRITE_HIDDEN = 2'd2;

  localparam int          ADDR_W            = 3;
  localparam logic [2:0]  REG_STATE_COUNT   = 3'd0;
  localparam logic [4:0]  STATE_COUNT_RESET = 5'd16;
  localparam int          FRAC_BITS         = 16;

  typedef struct packed {
    action_t            action;
    logic        [1:0]  batch_index;
    logic        [5:0]  channel_index;
    logic        [3:0]  state_index;
    logic signed [31:0] x_value;
    logic signed [31:0] a_coef;
    logic signed [31:0] b_coef;
    logic signed [31:0] c_coef;
    logic signed [31:0] skip_weight;
    logic signed [31:0] hidden_init;
  } item_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               saturated;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL_AH,
    ST_MUL_BX,
    ST_UPDATE,
    ST_MUL_CH,
    ST_ACC_Y,
    ST_MUL_SKIP,
    ST_ACC_SKIP,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

@@ design/selective_state_space_scan.sv @@
`default_nettype none
// selective state-space scan: one hidden value per batch, channel and state entry
// input channel (item_valid / item_stall / item): action 0 loads a, b, c for one
// state entry, action 2 writes one hidden entry, action 1 runs one sample x of a
// batch and channel through all state entries in use and gives one result
// output channel (result_valid / result_stall / result): y and the saturation flag
// actions 0 and 2 and ignored items are handled in the idle state; a sample
// steps one shared 32x32 multiplier and one saturating adder through three
// products and two sums per state entry in use, with the hidden store read
// through one port
// after reset the hidden store is swept to zero, one entry a cycle, through all
// MAX_BATCH*MAX_CHANNELS*STATE_SIZE entries (4096 by default); item_stall stays
// high meanwhile, configuration writes are taken at any time
// a finished result waits in an output register; the next item is taken while it
// waits, and a stalled receiver only holds the block back when a second result
// is ready before the first one has been taken
module selective_state_space_scan #(
  parameter int MAX_BATCH    = 4,
  parameter int MAX_CHANNELS = 64,
  parameter int STATE_SIZE   = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         item_valid,
  output logic                        item_stall,
  input  wire ssscan_pkg::item_t      item,
  output logic                        result_valid,
  input  wire                         result_stall,
  output ssscan_pkg::result_t         result,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [ssscan_pkg::ADDR_W-1:0] paddr,
  input  wire [31:0]                  pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ssscan_pkg::*;

  localparam int DEPTH = MAX_BATCH * MAX_CHANNELS * STATE_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
  localparam int SW    = $clog2(STATE_SIZE + 1);

  // configuration
  logic [4:0] state_count;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= STATE_COUNT_RESET;
    end else if (cfg_write && paddr == REG_STATE_COUNT) begin
      state_count <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_STATE_COUNT) begin
      prdata = {27'd0, state_count};
    end
  end

  // storage
  logic signed [31:0] hidden_mem [DEPTH];
  logic        [95:0] coef_mem [STATE_SIZE];
  logic signed [31:0] mem_q;
  logic        [95:0] coef_q;
  logic signed [31:0] coef_a, coef_b, coef_c;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic               coef_we;

  // control and datapath registers
  state_t             state, state_next;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      row_base;
  logic [SW-1:0]      s_idx;
  logic [SW-1:0]      s_last;
  logic signed [31:0] x_reg;
  logic signed [31:0] skip_reg;
  logic signed [31:0] h_reg;
  logic signed [31:0] y_reg;
  logic signed [47:0] term;
  logic signed [63:0] prod;
  logic               flag;

  // item decode
  logic               accept;
  logic               addr_ok;
  logic               state_ok;
  logic [31:0]        base_calc;
  logic [31:0]        n_calc;

  assign accept   = item_valid && !item_stall;
  assign addr_ok  = (32'(item.batch_index) < 32'(MAX_BATCH)) &&
                    (32'(item.channel_index) < 32'(MAX_CHANNELS));
  assign state_ok = 32'(item.state_index) < 32'(STATE_SIZE);
  assign base_calc = (32'(item.batch_index) * 32'(MAX_CHANNELS) + 32'(item.channel_index))
                     * 32'(STATE_SIZE);
  assign n_calc   = (32'(state_count) > 32'(STATE_SIZE)) ? 32'(STATE_SIZE)
                                                          : 32'(state_count);

  assign coef_we  = accept && item.action == ACT_LOAD_COEF && state_ok;
  assign mem_raddr = row_base + AW'(s_idx);
  assign coef_a   = coef_q[95:64];
  assign coef_b   = coef_q[63:32];
  assign coef_c   = coef_q[31:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hidden_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= hidden_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[CIW'(item.state_index)] <= {item.a_coef, item.b_coef, item.c_coef};
    end
    coef_q <= coef_mem[CIW'(s_idx)];
  end

  // shared multiplier and saturating adder
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] prod_q;
  logic signed [47:0] add_a;
  logic signed [49:0] sum;
  logic signed [31:0] sum_sat;
  logic               sum_ovf;

  assign prod_q = prod[63:FRAC_BITS];

  always_comb begin
    case (state)
      ST_MUL_BX: begin
        mul_a = coef_b;
        mul_b = x_reg;
      end
      ST_MUL_CH: begin
        mul_a = coef_c;
        mul_b = h_reg;
      end
      ST_MUL_SKIP: begin
        mul_a = skip_reg;
        mul_b = x_reg;
      end
      default: begin
        mul_a = coef_a;
        mul_b = mem_q;
      end
    endcase
  end

  always_comb begin
    add_a = (state == ST_UPDATE) ? term : {{16{y_reg[31]}}, y_reg};
    sum   = {{2{add_a[47]}}, add_a} + {{2{prod_q[47]}}, prod_q};
    if (sum > 50'sd2147483647) begin
      sum_sat = 32'sh7fffffff;
      sum_ovf = 1'b1;
    end else if (sum < -50'sd2147483648) begin
      sum_sat = 32'sh80000000;
      sum_ovf = 1'b1;
    end else begin
      sum_sat = sum[31:0];
      sum_ovf = 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = mem_raddr;
    mem_wdata  = sum_sat;
    item_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && addr_ok) begin
          if (item.action == ACT_WRITE_HIDDEN && state_ok) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(base_calc + 32'(item.state_index));
            mem_wdata = item.hidden_init;
          end
          if (item.action == ACT_SAMPLE) begin
            state_next = (n_calc == 32'd0) ? ST_MUL_SKIP : ST_READ;
          end
        end
      end
      ST_READ:     state_next = ST_MUL_AH;
      ST_MUL_AH:   state_next = ST_MUL_BX;
      ST_MUL_BX:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        mem_we     = 1'b1;
        state_next = ST_MUL_CH;
      end
      ST_MUL_CH:   state_next = ST_ACC_Y;
      ST_ACC_Y:    state_next = (s_idx == s_last) ? ST_MUL_SKIP : ST_READ;
      ST_MUL_SKIP: state_next = ST_ACC_SKIP;
      ST_ACC_SKIP: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          row_base <= AW'(base_calc);
          x_reg    <= item.x_value;
          skip_reg <= item.skip_weight;
          s_idx    <= '0;
          s_last   <= SW'(n_calc - 32'd1);
          y_reg    <= '0;
          flag     <= 1'b0;
        end
      end
      ST_MUL_BX: begin
        term <= prod_q;
      end
      ST_UPDATE: begin
        h_reg <= sum_sat;
        flag  <= flag | sum_ovf;
      end
      ST_ACC_Y: begin
        y_reg <= sum_sat;
        flag  <= flag | sum_ovf;
        s_idx <= s_idx + SW'(1);
      end
      ST_ACC_SKIP: begin
        y_reg <= sum_sat;
        flag  <= flag | sum_ovf;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!result_valid || !result_stall)) begin
      result.y_value   <= y_reg;
      result.saturated <= flag;
    end
  end

endmodule
`default_nettype wire
